[sv/ffs_pkg.sv]
// Shared types and constants of the filament feed supervisor.
package ffs_pkg;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_FEED    = 3'd1;
  localparam logic [2:0] CMD_RETRACT = 3'd2;
  localparam logic [2:0] CMD_DRY     = 3'd3;
  localparam logic [2:0] CMD_ABORT   = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_STARTED  = 3'd1;
  localparam logic [2:0] EV_REJECTED = 3'd2;
  localparam logic [2:0] EV_COLD     = 3'd3;
  localparam logic [2:0] EV_RUNOUT   = 3'd4;
  localparam logic [2:0] EV_JAM      = 3'd5;
  localparam logic [2:0] EV_DONE     = 3'd6;
  localparam logic [2:0] EV_ABORTED  = 3'd7;

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_FEED_A = 3'd1;
  localparam logic [2:0] MODE_FEED_B = 3'd2;
  localparam logic [2:0] MODE_RET_A  = 3'd3;
  localparam logic [2:0] MODE_RET_B  = 3'd4;
  localparam logic [2:0] MODE_DRY    = 3'd5;

  localparam logic [0:0] REG_JAM_THRESHOLD = 1'd0;
  localparam logic [0:0] REG_JAM_WINDOW    = 1'd1;

  localparam logic [23:0] MIN_FED_FOR_JAM = 24'd1000;
  localparam logic [23:0] MAX24 = 24'hFFFFFF;
  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
  localparam logic [15:0] MAX16 = 16'hFFFF;
  localparam int DIV_STEPS = 34;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
  } ctrl_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
  } stat_t;

endpackage

[sv/ffs_ctrl.sv]
// Controller state machine of the filament feed supervisor.
module ffs_ctrl import ffs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output logic  in_stall,
  output logic  out_valid,
  output ctrl_t ctrl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = stat.div_needed ? ST_DIV : ST_OUT;
      ST_DIV:  if (stat.div_last) state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = in_valid ? ST_EVAL : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        ctrl.load = in_valid;
      end
      ST_EVAL: ctrl.eval = 1'b1;
      ST_DIV: ctrl.div_step = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        in_stall = out_stall;
        ctrl.load = in_valid && !out_stall;
      end
      default: ;
    endcase
  end

endmodule

[sv/ffs_datapath.sv]
// Datapath of the filament feed supervisor: state, statistics and rate divider.
module ffs_datapath import ffs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_t              ctrl,
  output stat_t              stat,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic [2:0]         in_cmd,
  input  logic [31:0]        in_now_ms,
  input  logic signed [31:0] in_encoder_pos,
  input  logic               in_sensor_a_empty,
  input  logic               in_sensor_b_empty,
  input  logic               in_motor_idle,
  input  logic               in_cold_block,
  input  logic               in_input_select,
  input  logic [23:0]        in_length,
  output logic [2:0]         out_event_res,
  output logic [2:0]         out_mode,
  output logic [3:0]         out_status_flags,
  output logic               out_move_axis,
  output logic signed [24:0] out_move_distance,
  output logic [23:0]        out_fed_distance,
  output logic [39:0]        out_total_fed_a,
  output logic [39:0]        out_total_fed_b,
  output logic [15:0]        out_runout_count,
  output logic [15:0]        out_jam_count,
  output logic [23:0]        out_average_rate
);

  logic [19:0] thr_r;
  logic [15:0] win_r;
  logic [2:0]  cmd_r;
  logic [31:0] now_r;
  logic signed [31:0] enc_r;
  logic ea_r, eb_r, midle_r, cold_r, sel_r;
  logic [23:0] len_r;

  logic [2:0]  mode_r, mode_nxt;
  logic        act_r, act_nxt;
  logic [23:0] fed_r, fed_nxt;
  logic signed [31:0] spos_r, spos_nxt, wpos_r, wpos_nxt;
  logic [31:0] stime_r, stime_nxt, wtime_r, wtime_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [39:0] suma_r, suma_nxt, sumb_r, sumb_nxt;
  logic [15:0] runc_r, runc_nxt, jamc_r, jamc_nxt;
  logic [23:0] rate_r;
  logic [2:0]  ev_r, ev_nxt;
  logic        axis_r, axis_nxt;
  logic signed [24:0] dist_r, dist_nxt;
  logic        clr_rate;

  // Restoring divider: fed * 1000 (34 bits) by elapsed time (32 bits).
  logic [33:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        div_need;
  logic [33:0] dividend;
  logic [31:0] elapsed;
  logic [32:0] trial;
  logic [32:0] rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 20'd500;
      win_r <= 16'd500;
    end else if (cfg_valid) begin
      if (cfg_index == REG_JAM_THRESHOLD) thr_r <= cfg_data;
      else win_r <= cfg_data[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_cmd; now_r <= in_now_ms; enc_r <= in_encoder_pos;
      ea_r <= in_sensor_a_empty; eb_r <= in_sensor_b_empty;
      midle_r <= in_motor_idle; cold_r <= in_cold_block;
      sel_r <= in_input_select; len_r <= in_length;
    end
  end

  logic [32:0] dwin, dstart;
  logic [32:0] adwin, adstart;
  logic [42:0] lhs;
  logic [35:0] rhs;
  logic [31:0] wdiff;

  always_comb begin
    mode_nxt = mode_r; act_nxt = act_r; fed_nxt = fed_r;
    spos_nxt = spos_r; wpos_nxt = wpos_r; stime_nxt = stime_r; wtime_nxt = wtime_r;
    flags_nxt = flags_r; suma_nxt = suma_r; sumb_nxt = sumb_r;
    runc_nxt = runc_r; jamc_nxt = jamc_r;
    ev_nxt = EV_NONE; axis_nxt = 1'b0; dist_nxt = '0;
    div_need = 1'b0; clr_rate = 1'b0;
    dividend = '0;
    elapsed = now_r - stime_r;
    dwin = {enc_r[31], enc_r} - {wpos_r[31], wpos_r};
    adwin = dwin[32] ? 33'd0 - dwin : dwin;
    dstart = {enc_r[31], enc_r} - {spos_r[31], spos_r};
    adstart = dstart[32] ? 33'd0 - dstart : dstart;
    lhs = {10'd0, adwin} * 43'd1000;
    rhs = thr_r * win_r;
    wdiff = now_r - wtime_r;
    unique case (cmd_r)
      CMD_TICK: begin
        if (mode_r != MODE_IDLE) begin
          flags_nxt[3:2] = {eb_r, ea_r};
          if ((mode_r == MODE_FEED_A && ea_r) || (mode_r == MODE_FEED_B && eb_r)) begin
            runc_nxt = (runc_r == MAX16) ? runc_r : runc_r + 16'd1;
            mode_nxt = MODE_IDLE; flags_nxt[0] = 1'b0; ev_nxt = EV_RUNOUT;
          end
          if (mode_nxt >= MODE_FEED_A && mode_nxt <= MODE_RET_B && wdiff >= {16'd0, win_r}) begin
            wtime_nxt = now_r; wpos_nxt = enc_r;
            if (lhs < {7'd0, rhs} && fed_r > MIN_FED_FOR_JAM) begin
              flags_nxt[1] = 1'b1;
              jamc_nxt = (jamc_r == MAX16) ? jamc_r : jamc_r + 16'd1;
              mode_nxt = MODE_IDLE; flags_nxt[0] = 1'b0; ev_nxt = EV_JAM;
            end
          end
          fed_nxt = (adstart > {9'd0, MAX24}) ? MAX24 : adstart[23:0];
          if (midle_r) begin
            flags_nxt[0] = 1'b1;
            mode_nxt = MODE_IDLE;
            if (!act_r) suma_nxt = (suma_r + {16'd0, fed_nxt} < suma_r) ? MAX40
                                   : suma_r + {16'd0, fed_nxt};
            else sumb_nxt = (sumb_r + {16'd0, fed_nxt} < sumb_r) ? MAX40
                            : sumb_r + {16'd0, fed_nxt};
            div_need = (elapsed != 32'd0);
            dividend = {10'd0, fed_nxt} * 34'd1000;
            if (ev_nxt == EV_NONE) ev_nxt = EV_DONE;
          end
        end
      end
      CMD_FEED, CMD_RETRACT, CMD_DRY: begin
        if (mode_r != MODE_IDLE || len_r == 24'd0) ev_nxt = EV_REJECTED;
        else if (cmd_r == CMD_FEED && cold_r) ev_nxt = EV_COLD;
        else begin
          act_nxt = sel_r; fed_nxt = '0;
          spos_nxt = enc_r; wpos_nxt = enc_r;
          stime_nxt = now_r; wtime_nxt = now_r;
          flags_nxt[1:0] = 2'b00;
          if (cmd_r == CMD_FEED) mode_nxt = sel_r ? MODE_FEED_B : MODE_FEED_A;
          else if (cmd_r == CMD_RETRACT) mode_nxt = sel_r ? MODE_RET_B : MODE_RET_A;
          else mode_nxt = MODE_DRY;
          axis_nxt = sel_r;
          dist_nxt = (cmd_r == CMD_RETRACT) ? -$signed({1'b0, len_r})
                                            : $signed({1'b0, len_r});
          ev_nxt = EV_STARTED;
        end
      end
      CMD_ABORT: begin
        mode_nxt = MODE_IDLE; flags_nxt[0] = 1'b0; ev_nxt = EV_ABORTED;
      end
      CMD_CLEAR: begin
        suma_nxt = '0; sumb_nxt = '0; runc_nxt = '0; jamc_nxt = '0; clr_rate = 1'b1;
      end
      default: ;
    endcase
  end

  // Run state and statistics registers, loaded when an item is evaluated; the 40-bit totals saturate at their limit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE; act_r <= 1'b0; fed_r <= '0;
      spos_r <= '0; wpos_r <= '0; stime_r <= '0; wtime_r <= '0;
      flags_r <= '0; suma_r <= '0; sumb_r <= '0; runc_r <= '0; jamc_r <= '0;
      ev_r <= EV_NONE; axis_r <= 1'b0; dist_r <= '0;
    end else if (ctrl.eval) begin
      mode_r <= mode_nxt; act_r <= act_nxt; fed_r <= fed_nxt;
      spos_r <= spos_nxt; wpos_r <= wpos_nxt; stime_r <= stime_nxt; wtime_r <= wtime_nxt;
      flags_r <= flags_nxt; suma_r <= suma_nxt; sumb_r <= sumb_nxt;
      runc_r <= runc_nxt; jamc_r <= jamc_nxt;
      ev_r <= ev_nxt; axis_r <= axis_nxt; dist_r <= dist_nxt;
    end
  end

  assign rem_sh = {rem_r, quo_r[33]};
  assign trial  = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rate_r <= '0;
    end else if (ctrl.eval) begin
      if (clr_rate) rate_r <= '0;
      quo_r <= dividend; rem_r <= '0; dvs_r <= elapsed;
      cnt_r <= 6'(DIV_STEPS - 1);
    end else if (ctrl.div_step) begin
      if (!trial[32]) begin
        rem_r <= trial[31:0]; quo_r <= {quo_r[32:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0]; quo_r <= {quo_r[32:0], 1'b0};
      end
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        if (!trial[32]) rate_r <= (quo_r[32:23] != '0) ? MAX24 : {quo_r[22:0], 1'b1};
        else rate_r <= (quo_r[32:23] != '0) ? MAX24 : {quo_r[22:0], 1'b0};
      end
    end
  end

  assign stat.div_needed = div_need;
  assign stat.div_last   = (cnt_r == 6'd0);

  assign out_event_res     = ev_r;
  assign out_mode          = mode_r;
  assign out_status_flags  = flags_r;
  assign out_move_axis     = axis_r;
  assign out_move_distance = dist_r;
  assign out_fed_distance  = fed_r;
  assign out_total_fed_a   = suma_r;
  assign out_total_fed_b   = sumb_r;
  assign out_runout_count  = runc_r;
  assign out_jam_count     = jamc_r;
  assign out_average_rate  = rate_r;

endmodule

[sv/filament_feed_supervisor_core.sv]
// Top level of the filament feed supervisor.
//
// One request on the input channel carries a command with its time stamp,
// encoder position, sensor bits and start arguments; each request yields
// exactly one result request carrying the event, run mode, flags, move
// request and statistics. An item is accepted when in_valid is high and
// in_stall low; a result is taken when out_valid is high and out_stall low.
// After acceptance an item passes through the evaluate state to the result
// state, and also through the divide state when a tick completes a run with
// nonzero elapsed time: the average rate comes from a one-bit-per-cycle
// restoring divider of 34 steps. One item is in work at a time; the next is
// accepted in the cycle its predecessor's result is taken. While the receiver
// stalls, the result holds and no new item is accepted.
// The registers jam_threshold (index 0) and jam_window (index 1) are written
// through the cfg channel, which is always ready; write only while idle.
// Synchronous reset clears all run state and statistics and loads 500 into
// both registers.
module filament_feed_supervisor_core import ffs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic [31:0]        in_now_ms,
  input  logic signed [31:0] in_encoder_pos,
  input  logic               in_sensor_a_empty,
  input  logic               in_sensor_b_empty,
  input  logic               in_motor_idle,
  input  logic               in_cold_block,
  input  logic               in_input_select,
  input  logic [23:0]        in_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_event_res,
  output logic [2:0]         out_mode,
  output logic [3:0]         out_status_flags,
  output logic               out_move_axis,
  output logic signed [24:0] out_move_distance,
  output logic [23:0]        out_fed_distance,
  output logic [39:0]        out_total_fed_a,
  output logic [39:0]        out_total_fed_b,
  output logic [15:0]        out_runout_count,
  output logic [15:0]        out_jam_count,
  output logic [23:0]        out_average_rate
);

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ffs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .out_stall, .stat, .in_stall, .out_valid, .ctrl
  );

  ffs_datapath u_dp (
    .clk, .rst_n, .ctrl, .stat, .cfg_valid, .cfg_index, .cfg_data,
    .in_cmd, .in_now_ms, .in_encoder_pos, .in_sensor_a_empty, .in_sensor_b_empty,
    .in_motor_idle, .in_cold_block, .in_input_select, .in_length,
    .out_event_res, .out_mode, .out_status_flags, .out_move_axis,
    .out_move_distance, .out_fed_distance, .out_total_fed_a, .out_total_fed_b,
    .out_runout_count, .out_jam_count, .out_average_rate
  );

`ifndef SYNTHESIS
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input accepted while result stalled");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_event_res)))
    else $error("stalled result changed");
  a_started_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_STARTED) |-> (out_move_distance == '0))
    else $error("move request without start");
`endif

endmodule

[bench/tb_filament_feed_supervisor_core.sv]
// Self-checking testbench for the filament feed supervisor core.
`timescale 1ns / 1ps

module tb_filament_feed_supervisor_core;
  import ffs_pkg::*;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [31:0]        now_ms;
    logic signed [31:0] encoder_pos;
    logic               sensor_a_empty;
    logic               sensor_b_empty;
    logic               motor_idle;
    logic               cold_block;
    logic               input_select;
    logic [23:0]        length;
  } feed_req_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [2:0]         mode;
    logic [3:0]         status_flags;
    logic               move_axis;
    logic signed [24:0] move_distance;
    logic [23:0]        fed_distance;
    logic [39:0]        total_fed_a;
    logic [39:0]        total_fed_b;
    logic [15:0]        runout_count;
    logic [15:0]        jam_count;
    logic [23:0]        average_rate;
  } feed_rsp_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [19:0] cfg_data;
  logic in_valid;
  logic in_stall;
  feed_req_t cur_req;
  logic out_valid;
  logic out_stall;
  feed_rsp_t got;

  filament_feed_supervisor_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(cur_req.cmd), .in_now_ms(cur_req.now_ms),
    .in_encoder_pos(cur_req.encoder_pos),
    .in_sensor_a_empty(cur_req.sensor_a_empty),
    .in_sensor_b_empty(cur_req.sensor_b_empty),
    .in_motor_idle(cur_req.motor_idle), .in_cold_block(cur_req.cold_block),
    .in_input_select(cur_req.input_select), .in_length(cur_req.length),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_res(got.event_res), .out_mode(got.mode),
    .out_status_flags(got.status_flags), .out_move_axis(got.move_axis),
    .out_move_distance(got.move_distance), .out_fed_distance(got.fed_distance),
    .out_total_fed_a(got.total_fed_a), .out_total_fed_b(got.total_fed_b),
    .out_runout_count(got.runout_count), .out_jam_count(got.jam_count),
    .out_average_rate(got.average_rate)
  );

  // Predictor state.
  logic [19:0] jam_thr;
  logic [15:0] jam_win;
  logic [2:0]  run_mode;
  logic        act_input;
  logic [23:0] fed_run;
  logic signed [31:0] start_pos, win_pos;
  logic [31:0] start_ms, win_ms;
  logic [3:0]  flags;
  logic [39:0] sum_a, sum_b;
  logic [15:0] runouts, jams;
  logic [23:0] rate;

  feed_req_t pending_reqs[$];
  feed_rsp_t expected_rsps[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  long_hold = 0;
  int  hold_left = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  bit  in_taken = 0;

  function automatic logic [63:0] abs_delta(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d < 0 ? -d : d;
  endfunction

  function automatic logic [15:0] bump16(logic [15:0] c);
    return c == MAX16 ? c : c + 16'd1;
  endfunction

  function automatic feed_rsp_t supervise(feed_req_t r);
    feed_rsp_t o;
    logic [63:0] delta, prod, sum;
    logic [31:0] el;
    o = '0;
    o.event_res = EV_NONE;
    case (r.cmd)
      CMD_TICK: begin
        if (run_mode != MODE_IDLE) begin
          flags[2] = r.sensor_a_empty;
          flags[3] = r.sensor_b_empty;
          if ((run_mode == MODE_FEED_A && r.sensor_a_empty) ||
              (run_mode == MODE_FEED_B && r.sensor_b_empty)) begin
            runouts = bump16(runouts);
            run_mode = MODE_IDLE; flags[0] = 1'b0; o.event_res = EV_RUNOUT;
          end
          if (run_mode >= MODE_FEED_A && run_mode <= MODE_RET_B &&
              (r.now_ms - win_ms) >= {16'd0, jam_win}) begin
            delta = abs_delta(r.encoder_pos, win_pos);
            win_ms = r.now_ms;
            win_pos = r.encoder_pos;
            prod = 64'(jam_thr) * 64'(jam_win);
            if (delta * 1000 < prod && fed_run > MIN_FED_FOR_JAM) begin
              flags[1] = 1'b1;
              jams = bump16(jams);
              run_mode = MODE_IDLE; flags[0] = 1'b0; o.event_res = EV_JAM;
            end
          end
          delta = abs_delta(r.encoder_pos, start_pos);
          fed_run = delta > 64'(MAX24) ? MAX24 : delta[23:0];
          if (r.motor_idle) begin
            el = r.now_ms - start_ms;
            flags[0] = 1'b1;
            run_mode = MODE_IDLE;
            if (!act_input) begin
              sum = 64'(sum_a) + 64'(fed_run);
              sum_a = sum > 64'(MAX40) ? MAX40 : sum[39:0];
            end else begin
              sum = 64'(sum_b) + 64'(fed_run);
              sum_b = sum > 64'(MAX40) ? MAX40 : sum[39:0];
            end
            if (el != 0) begin
              prod = 64'(fed_run) * 1000 / 64'(el);
              rate = prod > 64'(MAX24) ? MAX24 : prod[23:0];
            end
            if (o.event_res == EV_NONE) o.event_res = EV_DONE;
          end
        end
      end
      CMD_FEED, CMD_RETRACT, CMD_DRY: begin
        if (run_mode != MODE_IDLE || r.length == 0) o.event_res = EV_REJECTED;
        else if (r.cmd == CMD_FEED && r.cold_block) o.event_res = EV_COLD;
        else begin
          act_input = r.input_select;
          fed_run = '0;
          start_pos = r.encoder_pos; win_pos = r.encoder_pos;
          start_ms = r.now_ms; win_ms = r.now_ms;
          flags[1] = 1'b0; flags[0] = 1'b0;
          if (r.cmd == CMD_FEED) run_mode = r.input_select ? MODE_FEED_B : MODE_FEED_A;
          else if (r.cmd == CMD_RETRACT) run_mode = r.input_select ? MODE_RET_B : MODE_RET_A;
          else run_mode = MODE_DRY;
          o.move_axis = r.input_select;
          o.move_distance = r.cmd == CMD_RETRACT ? -$signed({1'b0, r.length})
                                                 : $signed({1'b0, r.length});
          o.event_res = EV_STARTED;
        end
      end
      CMD_ABORT: begin
        run_mode = MODE_IDLE; flags[0] = 1'b0; o.event_res = EV_ABORTED;
      end
      CMD_CLEAR: begin
        sum_a = '0; sum_b = '0; rate = '0; runouts = '0; jams = '0;
      end
      default: ;
    endcase
    o.mode = run_mode;
    o.status_flags = flags;
    o.fed_distance = fed_run;
    o.total_fed_a = sum_a;
    o.total_fed_b = sum_b;
    o.runout_count = runouts;
    o.jam_count = jams;
    o.average_rate = rate;
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The handshake is judged at the rising edge; the sender acts on it at the next falling edge.
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        expected_rsps.push_back(supervise(cur_req));
      end
      if (!in_valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (long_hold) begin
        long_hold <= 1'b0;
        hold_left <= 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("tb_filament_feed_supervisor_core: FAIL");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("result with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          feed_rsp_t e;
          e = expected_rsps.pop_front();
          if (e != got) begin
            fail_count <= fail_count + 1;
            if (e.event_res != got.event_res)
              $error("event_res exp %0d got %0d", e.event_res, got.event_res);
            if (e.mode != got.mode) $error("mode exp %0d got %0d", e.mode, got.mode);
            if (e.status_flags != got.status_flags)
              $error("status_flags exp %h got %h", e.status_flags, got.status_flags);
            if (e.move_axis != got.move_axis)
              $error("move_axis exp %0d got %0d", e.move_axis, got.move_axis);
            if (e.move_distance != got.move_distance)
              $error("move_distance exp %0d got %0d", e.move_distance, got.move_distance);
            if (e.fed_distance != got.fed_distance)
              $error("fed_distance exp %0d got %0d", e.fed_distance, got.fed_distance);
            if (e.total_fed_a != got.total_fed_a)
              $error("total_fed_a exp %0d got %0d", e.total_fed_a, got.total_fed_a);
            if (e.total_fed_b != got.total_fed_b)
              $error("total_fed_b exp %0d got %0d", e.total_fed_b, got.total_fed_b);
            if (e.runout_count != got.runout_count)
              $error("runout_count exp %0d got %0d", e.runout_count, got.runout_count);
            if (e.jam_count != got.jam_count)
              $error("jam_count exp %0d got %0d", e.jam_count, got.jam_count);
            if (e.average_rate != got.average_rate)
              $error("average_rate exp %0d got %0d", e.average_rate, got.average_rate);
          end
        end
      end
    end
  end

  function automatic feed_req_t blank_req(logic [2:0] c, logic [31:0] t,
                                           logic signed [31:0] p);
    feed_req_t r;
    r = '0;
    r.cmd = c; r.now_ms = t; r.encoder_pos = p;
    return r;
  endfunction

  task automatic add_start(logic [2:0] c, logic sel, logic [23:0] len,
                           logic [31:0] t, logic signed [31:0] p, logic cold);
    feed_req_t r;
    r = blank_req(c, t, p);
    r.input_select = sel; r.length = len; r.cold_block = cold;
    pending_reqs.push_back(r);
  endtask

  task automatic add_tick(logic [31:0] t, logic signed [31:0] p, logic ea, logic eb,
                          logic midle);
    feed_req_t r;
    r = blank_req(CMD_TICK, t, p);
    r.sensor_a_empty = ea; r.sensor_b_empty = eb; r.motor_idle = midle;
    r.length = $urandom; r.input_select = $urandom; r.cold_block = $urandom;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [19:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_JAM_THRESHOLD) jam_thr = val;
    else jam_win = val[15:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One realistic run: a start, a string of ticks with moving encoder, often a finish.
  task automatic add_run(logic [31:0] t0, int steps_max);
    logic signed [31:0] p;
    logic [31:0] t;
    logic [2:0] c;
    int n;
    p = $urandom; t = t0;
    c = $urandom_range(1, 3);
    add_start(c, $urandom, ($urandom_range(0, 20) == 0) ? 24'd0 : $urandom,
              t, p, $urandom_range(0, 5) == 0);
    n = $urandom_range(1, steps_max);
    for (int k = 0; k < n; k++) begin
      t += $urandom_range(0, 3) == 0 ? $urandom_range(0, 2000) : $urandom_range(0, 50);
      case ($urandom_range(0, 3))
        0: p += $urandom_range(0, 20);
        1: p -= $urandom_range(0, 20000);
        default: p += $urandom_range(0, 20000);
      endcase
      add_tick(t, p, $urandom_range(0, 30) == 0, $urandom_range(0, 30) == 0,
               k == n - 1 ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 40) == 0));
    end
  endtask

  task automatic add_noise();
    feed_req_t r;
    r = $urandom;
    r.now_ms = $urandom; r.encoder_pos = $urandom; r.length = $urandom;
    r.cmd = $urandom_range(0, 7);
    pending_reqs.push_back(r);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    in_valid = 1'b0; out_stall = 1'b0; cur_req = '0;
    jam_thr = 20'd500; jam_win = 16'd500;
    run_mode = MODE_IDLE; act_input = 1'b0; fed_run = '0;
    start_pos = '0; win_pos = '0; start_ms = '0; win_ms = '0; flags = '0;
    sum_a = '0; sum_b = '0; runouts = '0; jams = '0; rate = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    add_tick(32'd5, 32'sd0, 1, 1, 1);                       // tick while idle
    add_start(CMD_FEED, 0, 24'd0, 32'd10, 32'sd0, 0);       // zero length
    add_start(CMD_FEED, 1, 24'd100, 32'd10, 32'sd0, 1);     // cold block
    add_start(CMD_FEED, 0, 24'hFFFFFF, 32'hFFFFFFF0, 32'sh7FFFFFFF, 0);
    add_start(CMD_DRY, 1, 24'd5, 32'd0, 32'sd0, 0);         // not idle
    add_tick(32'hFFFFFFFF, 32'sh7FFFFFF0, 0, 1, 0);         // flags only
    add_tick(32'd600, 32'sh7FFFF000, 0, 0, 0);              // wrap, fed > 1000
    add_tick(32'd1200, 32'sh7FFFF001, 0, 0, 1);             // jam then completes
    add_start(CMD_RETRACT, 1, 24'hFFFFFF, 32'd0, 32'sh80000000, 1);
    add_tick(32'd0, 32'sh7FFFFFFF, 1, 1, 1);                // saturate, zero elapsed
    add_start(CMD_FEED, 1, 24'd1, 32'd50, 32'sd0, 0);
    add_tick(32'd60, 32'sd3000, 0, 1, 1);                   // runout then completes
    add_start(CMD_DRY, 0, 24'd77, 32'd70, 32'sd0, 0);
    add_tick(32'd80, -32'sd5000, 1, 0, 0);
    pending_reqs.push_back(blank_req(CMD_ABORT, 32'd90, 32'sd0));
    pending_reqs.push_back(blank_req(CMD_ABORT, 32'd91, 32'sd0));
    pending_reqs.push_back(blank_req(3'd6, 32'd92, 32'sd0));
    pending_reqs.push_back(blank_req(3'd7, 32'd93, 32'sd0));
    pending_reqs.push_back(blank_req(CMD_CLEAR, 32'd94, 32'sd0));
    drain();

    // Random phases, each with its own register setting, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_JAM_THRESHOLD, 20'd0); write_reg(REG_JAM_WINDOW, 20'd1); end
        1: begin write_reg(REG_JAM_THRESHOLD, 20'hFFFFF); write_reg(REG_JAM_WINDOW, 20'hFFFF); end
        2: begin write_reg(REG_JAM_THRESHOLD, 20'hFFFFF); write_reg(REG_JAM_WINDOW, 20'd1); end
        3: begin write_reg(REG_JAM_THRESHOLD, 20'd20000); write_reg(REG_JAM_WINDOW, 20'd50); end
        default: begin
          write_reg(REG_JAM_THRESHOLD, $urandom);
          write_reg(REG_JAM_WINDOW, $urandom_range(1, 3000));
        end
      endcase
      if (ph == 2) long_hold = 1'b1;
      while (pending_reqs.size() < 300) begin
        if ($urandom_range(0, 9) == 0) add_noise();
        else add_run($urandom, 12);
      end
      drain();
    end

    if (expected_rsps.size() != 0) fail_count++;
    if (fail_count == 0) $display("tb_filament_feed_supervisor_core: PASS");
    else $display("tb_filament_feed_supervisor_core: FAIL");
    $finish;
  end

endmodule

[files.f]
sv/ffs_pkg.sv
sv/ffs_ctrl.sv
sv/ffs_datapath.sv
sv/filament_feed_supervisor_core.sv
bench/tb_filament_feed_supervisor_core.sv
